// ----- rtl/dttpi_pkg.sv -----
// Shared types, widths and constants for the drive-to-target dual PI controller.
// No dependencies; imported by dttpi_power, drive_to_target_pi and the testbench.
package dttpi_pkg;

  localparam int unsigned CNT_W      = 24;
  localparam int unsigned DIFF_W     = 25;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned ERR_W      = 13;
  localparam int unsigned MM_W       = 12;
  localparam int unsigned GAIN_W     = 20;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned PWR_W      = 8;
  localparam int unsigned PH_W       = 2;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned PROD_W     = 53;
  localparam int unsigned Q_SHIFT    = 16;
  localparam int unsigned Q_W        = PROD_W - Q_SHIFT;
  localparam int unsigned POW_W      = 40;

  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [PH_W-1:0] PH_SEARCH   = 2'd0;
  localparam logic [PH_W-1:0] PH_APPROACH = 2'd1;
  localparam logic [PH_W-1:0] PH_DONE     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOL      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_KP  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_KI  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_KP  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_KI  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BAND     = 4'd7;

  localparam logic [MM_W-1:0]   RST_TARGET  = 12'd200;
  localparam logic [MM_W-1:0]   RST_TOL     = 12'd10;
  localparam logic [GAIN_W-1:0] RST_DIST_KP = 20'd32768;
  localparam logic [GAIN_W-1:0] RST_DIST_KI = 20'd328;
  localparam logic [GAIN_W-1:0] RST_TURN_KP = 20'd52429;
  localparam logic [GAIN_W-1:0] RST_TURN_KI = 20'd6554;
  localparam logic [TICK_W-1:0] RST_SETTLE  = 16'd20;
  localparam logic [TICK_W-1:0] RST_BAND    = 16'd80;

  localparam logic signed [POW_W-1:0] SEARCH_POWER = 40'sd25;
  localparam logic signed [POW_W-1:0] SAT_LOW      = 40'sd20;
  localparam logic signed [POW_W-1:0] SAT_HIGH     = 40'sd40;
  localparam logic signed [POW_W-1:0] PWR_MAX      = 40'sd127;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_SEARCH,
    MODE_APPROACH
  } mode_e;

  typedef struct packed {
    mode_e                   mode;
    logic [PH_W-1:0]         phase;
    logic                    done;
    logic signed [ERR_W-1:0] err;
  } side_t;

  typedef struct packed {
    side_t                    side;
    logic signed [DIFF_W-1:0] diff;
    logic signed [ACC_W-1:0]  tsum;
    logic signed [ACC_W-1:0]  dsum;
  } pw_op_t;

  typedef struct packed {
    logic [GAIN_W-1:0] dist_kp;
    logic [GAIN_W-1:0] dist_ki;
    logic [GAIN_W-1:0] turn_kp;
    logic [GAIN_W-1:0] turn_ki;
  } gains_t;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/drive_to_target_pi.sv -----
// Top level of the drive-to-target dual PI controller: config registers, phase and
// integrator state, and the power pipeline. Depends on dttpi_pkg and dttpi_power.
//
// channel  | direction | handshake               | payload
// input    | in        | in_valid_i / in_stall_o | op, left/right_count, sonar_valid, sonar_mm
// result   | out       | out_valid_o/out_stall_i | left/right_power, phase_now, error_now, done_res
// config   | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One transaction per cycle while out_stall_i is low. Phase, integrators, last error and
// settle count update from the input register as the operand register loads; the four gain
// products then run through product, truncation, clamp and saturation stages. Reset clears
// valid bits and controller state and loads the default register values; no clearing pass.
// A stalled result holds the pipeline; empty stages keep filling behind it.
module drive_to_target_pi (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic signed [dttpi_pkg::CNT_W-1:0] left_count_i,
  input  logic signed [dttpi_pkg::CNT_W-1:0] right_count_i,
  input  logic                              sonar_valid_i,
  input  logic [dttpi_pkg::MM_W-1:0]        sonar_mm_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [dttpi_pkg::PWR_W-1:0] left_power_o,
  output logic signed [dttpi_pkg::PWR_W-1:0] right_power_o,
  output logic [dttpi_pkg::PH_W-1:0]        phase_now_o,
  output logic signed [dttpi_pkg::ERR_W-1:0] error_now_o,
  output logic                              done_res_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dttpi_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dttpi_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import dttpi_pkg::*;

  logic [MM_W-1:0]   target_q, tol_q;
  logic [TICK_W-1:0] settle_q, band_q;
  gains_t            gains_q;

  logic                     a_valid_q, a_op_q, a_sv_q;
  logic signed [CNT_W-1:0]  a_left_q, a_right_q;
  logic [MM_W-1:0]          a_mm_q;

  logic [PH_W-1:0]          ph_q, ph_d, ph_next;
  logic signed [ACC_W-1:0]  ts_q, ts_d, ds_q, ds_d;
  logic signed [ERR_W-1:0]  le_q, le_d;
  logic [TICK_W-1:0]        sc_q, sc_d;

  logic                     b_valid_q;
  pw_op_t                   b_op_q, b_op_d;
  logic                     pw_stall;
  logic                     en_a, en_b, a_fire;

  logic signed [DIFF_W-1:0] diff;
  logic signed [ACC_W-1:0]  ts_new, ds_new;
  logic signed [ERR_W-1:0]  err_new;
  logic signed [ERR_W:0]    e_x, tol_x;
  logic signed [TICK_W+1:0] e_b, band_x;
  logic                     in_tol_open, in_tol_closed, in_band;
  logic [TICK_W-1:0]        sc_new, sc_chk;
  mode_e                    mode;

  assign cfg_ready_o = 1'b1;
  assign en_b        = !b_valid_q || !pw_stall;
  assign en_a        = !a_valid_q || en_b;
  assign a_fire      = a_valid_q && en_b;
  assign in_stall_o  = !en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q        <= RST_TARGET;
      tol_q           <= RST_TOL;
      gains_q.dist_kp <= RST_DIST_KP;
      gains_q.dist_ki <= RST_DIST_KI;
      gains_q.turn_kp <= RST_TURN_KP;
      gains_q.turn_ki <= RST_TURN_KI;
      settle_q        <= RST_SETTLE;
      band_q          <= RST_BAND;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_TARGET:  target_q        <= cfg_data_i[MM_W-1:0];
        REG_TOL:     tol_q           <= cfg_data_i[MM_W-1:0];
        REG_DIST_KP: gains_q.dist_kp <= cfg_data_i[GAIN_W-1:0];
        REG_DIST_KI: gains_q.dist_ki <= cfg_data_i[GAIN_W-1:0];
        REG_TURN_KP: gains_q.turn_kp <= cfg_data_i[GAIN_W-1:0];
        REG_TURN_KI: gains_q.turn_ki <= cfg_data_i[GAIN_W-1:0];
        REG_SETTLE:  settle_q        <= cfg_data_i[TICK_W-1:0];
        REG_BAND:    band_q          <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign diff   = {a_left_q[CNT_W-1], a_left_q} - {a_right_q[CNT_W-1], a_right_q};
  assign ts_new = sat_acc({ts_q[ACC_W-1], ts_q}
                          + {{(ACC_W+1-DIFF_W){diff[DIFF_W-1]}}, diff});

  assign err_new = (ph_q == PH_APPROACH && a_sv_q)
                 ? $signed({1'b0, a_mm_q}) - $signed({1'b0, target_q}) : le_q;

  assign e_x           = {err_new[ERR_W-1], err_new};
  assign tol_x         = $signed({2'b00, tol_q});
  assign in_tol_open   = (e_x < tol_x) && (e_x > -tol_x);
  assign in_tol_closed = (e_x <= tol_x) && (e_x >= -tol_x);
  assign e_b           = {{(TICK_W+2-ERR_W){err_new[ERR_W-1]}}, err_new};
  assign band_x        = $signed({2'b00, band_q});
  assign in_band       = (e_b < band_x) && (e_b > -band_x);

  assign ds_new = in_band ? sat_acc({ds_q[ACC_W-1], ds_q}
                                    + {{(ACC_W+1-ERR_W){err_new[ERR_W-1]}}, err_new})
                          : ds_q;
  assign sc_new = (in_tol_open && sc_q != '1) ? sc_q + 1'b1 : sc_q;
  assign sc_chk = (ph_q == PH_APPROACH) ? sc_new : sc_q;

  always_comb begin
    ph_d    = ph_q;
    ts_d    = ts_q;
    ds_d    = ds_q;
    le_d    = le_q;
    sc_d    = sc_q;
    ph_next = ph_q;
    mode    = MODE_ZERO;
    b_op_d.diff = diff;
    b_op_d.tsum = ts_new;
    b_op_d.dsum = ds_q;
    b_op_d.side = '{mode: MODE_ZERO, phase: PH_SEARCH, done: 1'b0, err: '0};
    if (a_op_q == OP_RESTART) begin
      ph_d = PH_SEARCH;
      ts_d = '0;
      ds_d = '0;
      le_d = '0;
      sc_d = '0;
    end else if (ph_q >= PH_DONE) begin
      b_op_d.side = '{mode: MODE_ZERO, phase: PH_DONE, done: 1'b1, err: le_q};
    end else begin
      ts_d = ts_new;
      if (ph_q == PH_SEARCH) begin
        mode    = MODE_SEARCH;
        ph_next = a_sv_q ? PH_APPROACH : PH_SEARCH;
      end else begin
        mode    = MODE_APPROACH;
        ph_next = PH_APPROACH;
        le_d    = err_new;
        ds_d    = ds_new;
        sc_d    = sc_new;
      end
      b_op_d.dsum = ds_d;
      if (ph_next == PH_APPROACH && in_tol_closed && sc_chk >= settle_q) begin
        ph_d        = PH_DONE;
        b_op_d.side = '{mode: MODE_ZERO, phase: PH_DONE, done: 1'b1, err: le_d};
      end else begin
        ph_d        = ph_next;
        b_op_d.side = '{mode: mode, phase: ph_next, done: 1'b0, err: le_d};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      ph_q      <= PH_SEARCH;
      ts_q      <= '0;
      ds_q      <= '0;
      le_q      <= '0;
      sc_q      <= '0;
    end else begin
      if (en_a) a_valid_q <= in_valid_i;
      if (en_b) b_valid_q <= a_valid_q;
      if (a_fire) begin
        ph_q <= ph_d;
        ts_q <= ts_d;
        ds_q <= ds_d;
        le_q <= le_d;
        sc_q <= sc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && in_valid_i) begin
      a_op_q    <= op_i;
      a_left_q  <= left_count_i;
      a_right_q <= right_count_i;
      a_sv_q    <= sonar_valid_i;
      a_mm_q    <= sonar_mm_i;
    end
    if (a_fire) begin
      b_op_q <= b_op_d;
    end
  end

  dttpi_power u_power (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .gains_i       (gains_q),
    .op_valid_i    (b_valid_q),
    .op_i          (b_op_q),
    .op_stall_o    (pw_stall),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_power_o  (left_power_o),
    .right_power_o (right_power_o),
    .phase_now_o   (phase_now_o),
    .error_now_o   (error_now_o),
    .done_res_o    (done_res_o)
  );

endmodule

// ----- rtl/dttpi_power.sv -----
// Power pipeline: Q16 gain products, truncation, distance clamp and motor saturation.
// Depends on dttpi_pkg; instantiated by drive_to_target_pi.
module dttpi_power (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dttpi_pkg::gains_t                 gains_i,
  input  logic                              op_valid_i,
  input  dttpi_pkg::pw_op_t                 op_i,
  output logic                              op_stall_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [dttpi_pkg::PWR_W-1:0] left_power_o,
  output logic signed [dttpi_pkg::PWR_W-1:0] right_power_o,
  output logic [dttpi_pkg::PH_W-1:0]        phase_now_o,
  output logic signed [dttpi_pkg::ERR_W-1:0] error_now_o,
  output logic                              done_res_o
);
  import dttpi_pkg::*;

  localparam logic signed [PROD_W-1:0] Q_ROUND = {{(PROD_W-Q_SHIFT){1'b0}}, {Q_SHIFT{1'b1}}};

  function automatic logic signed [Q_W-1:0] q16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] adj;
    adj = p[PROD_W-1] ? p + Q_ROUND : p;
    return adj[Q_SHIFT +: Q_W];
  endfunction

  function automatic logic signed [PWR_W-1:0] sat_pwr(input logic signed [POW_W-1:0] v);
    logic signed [POW_W-1:0] c;
    c = v;
    if (v > PWR_MAX) c = PWR_MAX;
    if (v < -PWR_MAX) c = -PWR_MAX;
    return c[PWR_W-1:0];
  endfunction

  logic en1, en2, en3, en_o;

  logic                      v1_q, v2_q, v3_q;
  side_t                     s1_q, s2_q, s3_q;
  logic signed [PROD_W-1:0]  pa_q, pb_q, pc_q, pd_q;
  logic signed [Q_W-1:0]     qa_q, qb_q, qc_q, qd_q;
  logic signed [POW_W-1:0]   dpow_q, tpow_q;

  logic signed [PROD_W-1:0]  g_tkp, g_tki, g_dkp, g_dki;
  logic signed [PROD_W-1:0]  x_diff, x_tsum, x_err, x_dsum;
  logic signed [POW_W-1:0]   dpow_raw, dpow_d, tpow_d;
  logic signed [POW_W-1:0]   left_w, right_w;

  assign en_o       = !out_valid_o || !out_stall_i;
  assign en3        = !v3_q || en_o;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign op_stall_o = !en1;

  assign g_tkp  = {{(PROD_W-GAIN_W){1'b0}}, gains_i.turn_kp};
  assign g_tki  = {{(PROD_W-GAIN_W){1'b0}}, gains_i.turn_ki};
  assign g_dkp  = {{(PROD_W-GAIN_W){1'b0}}, gains_i.dist_kp};
  assign g_dki  = {{(PROD_W-GAIN_W){1'b0}}, gains_i.dist_ki};
  assign x_diff = {{(PROD_W-DIFF_W){op_i.diff[DIFF_W-1]}}, op_i.diff};
  assign x_tsum = {{(PROD_W-ACC_W){op_i.tsum[ACC_W-1]}}, op_i.tsum};
  assign x_err  = {{(PROD_W-ERR_W){op_i.side.err[ERR_W-1]}}, op_i.side.err};
  assign x_dsum = {{(PROD_W-ACC_W){op_i.dsum[ACC_W-1]}}, op_i.dsum};

  always_comb begin
    dpow_raw = {{(POW_W-Q_W){qc_q[Q_W-1]}}, qc_q} + {{(POW_W-Q_W){qd_q[Q_W-1]}}, qd_q};
    tpow_d   = {{(POW_W-Q_W){qa_q[Q_W-1]}}, qa_q} + {{(POW_W-Q_W){qb_q[Q_W-1]}}, qb_q};
    dpow_d   = dpow_raw;
    case (s2_q.mode)
      MODE_SEARCH: begin
        dpow_d = SEARCH_POWER;
      end
      MODE_APPROACH: begin
        if (s2_q.err > 0) begin
          if (dpow_raw < SAT_LOW) dpow_d = SAT_LOW;
          if (dpow_raw > SAT_HIGH) dpow_d = SAT_HIGH;
        end else if (s2_q.err < 0) begin
          if (dpow_raw < -SAT_HIGH) dpow_d = -SAT_HIGH;
          if (dpow_raw > -SAT_LOW) dpow_d = -SAT_LOW;
        end
      end
      default: begin
        dpow_d = '0;
      end
    endcase
  end

  assign left_w  = dpow_q - tpow_q;
  assign right_w = dpow_q + tpow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (en1) v1_q <= op_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en_o) out_valid_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && op_valid_i) begin
      s1_q <= op_i.side;
      pa_q <= g_tkp * x_diff;
      pb_q <= g_tki * x_tsum;
      pc_q <= g_dkp * x_err;
      pd_q <= g_dki * x_dsum;
    end
    if (en2 && v1_q) begin
      s2_q <= s1_q;
      qa_q <= q16(pa_q);
      qb_q <= q16(pb_q);
      qc_q <= q16(pc_q);
      qd_q <= q16(pd_q);
    end
    if (en3 && v2_q) begin
      s3_q   <= s2_q;
      dpow_q <= dpow_d;
      tpow_q <= tpow_d;
    end
    if (en_o && v3_q) begin
      if (s3_q.mode == MODE_ZERO) begin
        left_power_o  <= '0;
        right_power_o <= '0;
      end else begin
        left_power_o  <= sat_pwr(left_w);
        right_power_o <= sat_pwr(right_w);
      end
      phase_now_o <= s3_q.phase;
      error_now_o <= s3_q.err;
      done_res_o  <= s3_q.done;
    end
  end

endmodule

// ----- test/tb_drive_to_target_pi.sv -----
// Self-checking testbench for drive_to_target_pi: directed and random control ticks
// through valid/stall channels with a cycle-free predictor and an in-order scoreboard.
// Depends on dttpi_pkg and drive_to_target_pi.
`timescale 1ns / 1ps

module tb_drive_to_target_pi;
  import dttpi_pkg::*;

  localparam int     REG_COUNT       = 8;
  localparam longint CNT_MAX         = 2 ** (CNT_W - 1) - 1;
  localparam longint CNT_MIN         = -(2 ** (CNT_W - 1));
  localparam longint ACC_MAX         = (longint'(1) <<< (ACC_W - 1)) - 1;
  localparam longint ACC_MIN         = -(longint'(1) <<< (ACC_W - 1));
  localparam longint MM_MAX          = 2 ** MM_W - 1;
  localparam int     SETTLE_SAT      = 2 ** TICK_W - 1;
  localparam int     RAND_PHASES     = 12;
  localparam int     ITEMS_PER_PHASE = 120;
  localparam int     DRAIN_CYCLES    = 10;
  localparam int     REPORT_CAP      = 100;
  localparam longint TIMEOUT_NS      = 5_000_000;

  typedef struct packed {
    logic                    op;
    logic signed [CNT_W-1:0] lc;
    logic signed [CNT_W-1:0] rc;
    logic                    sv;
    logic [MM_W-1:0]         mm;
  } tick_t;

  typedef struct packed {
    logic signed [PWR_W-1:0] left_pw;
    logic signed [PWR_W-1:0] right_pw;
    logic [PH_W-1:0]         phase;
    logic signed [ERR_W-1:0] err;
    logic                    done;
  } drive_res_t;

  logic                     clk_i;
  logic                     rst_ni        = 1'b0;
  logic                     in_valid_i    = 1'b0;
  logic                     in_stall_o;
  logic                     op_i          = 1'b0;
  logic signed [CNT_W-1:0]  left_count_i  = '0;
  logic signed [CNT_W-1:0]  right_count_i = '0;
  logic                     sonar_valid_i = 1'b0;
  logic [MM_W-1:0]          sonar_mm_i    = '0;
  logic                     out_valid_o;
  logic                     out_stall_i   = 1'b0;
  logic signed [PWR_W-1:0]  left_power_o;
  logic signed [PWR_W-1:0]  right_power_o;
  logic [PH_W-1:0]          phase_now_o;
  logic signed [ERR_W-1:0]  error_now_o;
  logic                     done_res_o;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i    = '0;

  drive_to_target_pi dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .left_count_i  (left_count_i),
    .right_count_i (right_count_i),
    .sonar_valid_i (sonar_valid_i),
    .sonar_mm_i    (sonar_mm_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_power_o  (left_power_o),
    .right_power_o (right_power_o),
    .phase_now_o   (phase_now_o),
    .error_now_o   (error_now_o),
    .done_res_o    (done_res_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // controller copy: registers and state
  logic [MM_W-1:0]   tgt_mm;
  logic [MM_W-1:0]   tol_mm;
  logic [GAIN_W-1:0] dist_kp;
  logic [GAIN_W-1:0] dist_ki;
  logic [GAIN_W-1:0] steer_kp;
  logic [GAIN_W-1:0] steer_ki;
  logic [TICK_W-1:0] settle_need;
  logic [TICK_W-1:0] band_mm;
  logic [PH_W-1:0]   ctl_phase;
  longint            steer_sum;
  longint            dist_sum;
  longint            err_hold;
  int                settle_cnt;

  tick_t      pending_ticks[$];
  drive_res_t pending_powers[$];
  tick_t      next_tick;
  int         queued      = 0;
  int         bad_results = 0;
  int         send_gap    = 0;
  int         hold_gap    = 0;
  bit         in_fire     = 1'b0;
  bit         out_fire    = 1'b0;
  bit         in_calm     = 1'b0;
  bit         out_calm    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  function automatic int rnd(int lo, int hi);
    return int'($urandom_range(hi, lo));
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic longint gain_mul(logic [GAIN_W-1:0] g, longint x);
    return (longint'(g) * x) / 65536;
  endfunction

  function automatic int draw_gap(bit calm);
    if (calm || rnd(0, 3) == 0) return 0;
    return rnd(0, 10);
  endfunction

  function automatic void reset_model();
    tgt_mm      = RST_TARGET;
    tol_mm      = RST_TOL;
    dist_kp     = RST_DIST_KP;
    dist_ki     = RST_DIST_KI;
    steer_kp    = RST_TURN_KP;
    steer_ki    = RST_TURN_KI;
    settle_need = RST_SETTLE;
    band_mm     = RST_BAND;
    ctl_phase   = PH_SEARCH;
    steer_sum   = 0;
    dist_sum    = 0;
    err_hold    = 0;
    settle_cnt  = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_TARGET:  tgt_mm      = v[MM_W-1:0];
      REG_TOL:     tol_mm      = v[MM_W-1:0];
      REG_DIST_KP: dist_kp     = v[GAIN_W-1:0];
      REG_DIST_KI: dist_ki     = v[GAIN_W-1:0];
      REG_TURN_KP: steer_kp    = v[GAIN_W-1:0];
      REG_TURN_KI: steer_ki    = v[GAIN_W-1:0];
      REG_SETTLE:  settle_need = v[TICK_W-1:0];
      REG_BAND:    band_mm     = v[TICK_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic drive_res_t predict_drive(tick_t t);
    drive_res_t r;
    longint     diff;
    longint     tpow;
    longint     dpow;
    longint     e;
    longint     tol;
    r = '0;
    if (t.op == OP_RESTART) begin
      ctl_phase  = PH_SEARCH;
      steer_sum  = 0;
      dist_sum   = 0;
      err_hold   = 0;
      settle_cnt = 0;
      return r;
    end
    if (ctl_phase != PH_SEARCH && ctl_phase != PH_APPROACH) begin
      r.phase = PH_DONE;
      r.done  = 1'b1;
      r.err   = err_hold;
      return r;
    end
    diff      = longint'(t.lc) - longint'(t.rc);
    steer_sum = clip(steer_sum + diff, ACC_MIN, ACC_MAX);
    tpow      = gain_mul(steer_kp, diff) + gain_mul(steer_ki, steer_sum);
    tol       = longint'(tol_mm);
    if (ctl_phase == PH_SEARCH) begin
      dpow = SEARCH_POWER;
      if (t.sv) ctl_phase = PH_APPROACH;
    end else begin
      if (t.sv) err_hold = longint'(t.mm) - longint'(tgt_mm);
      e = err_hold;
      if (e > -longint'(band_mm) && e < longint'(band_mm))
        dist_sum = clip(dist_sum + e, ACC_MIN, ACC_MAX);
      dpow = gain_mul(dist_kp, e) + gain_mul(dist_ki, dist_sum);
      if (e > 0) dpow = clip(dpow, SAT_LOW, SAT_HIGH);
      else if (e < 0) dpow = clip(dpow, -SAT_HIGH, -SAT_LOW);
      if (e < tol && e > -tol && settle_cnt < SETTLE_SAT) settle_cnt++;
    end
    r.err = err_hold;
    if (ctl_phase == PH_APPROACH && err_hold <= tol && err_hold >= -tol &&
        settle_cnt >= settle_need) begin
      ctl_phase = PH_DONE;
      r.phase   = PH_DONE;
      r.done    = 1'b1;
      return r;
    end
    r.left_pw  = clip(dpow - tpow, -PWR_MAX, PWR_MAX);
    r.right_pw = clip(dpow + tpow, -PWR_MAX, PWR_MAX);
    r.phase    = ctl_phase;
    return r;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      bad_results++;
      if (bad_results <= REPORT_CAP) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // scoreboard: predict on input transaction, compare on result transaction
  always @(posedge clk_i) begin : scoreboard
    tick_t      seen;
    drive_res_t want;
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    if (in_fire) begin
      seen = '{op_i, left_count_i, right_count_i, sonar_valid_i, sonar_mm_i};
      pending_powers.push_back(predict_drive(seen));
    end
    if (out_fire) begin
      if (pending_powers.size() == 0) begin
        bad_results++;
        if (bad_results <= REPORT_CAP) $error("result transaction with nothing expected");
      end else begin
        want = pending_powers.pop_front();
        check_field("left_power", longint'(want.left_pw), longint'(left_power_o));
        check_field("right_power", longint'(want.right_pw), longint'(right_power_o));
        check_field("phase_now", longint'(want.phase), longint'(phase_now_o));
        check_field("error_now", longint'(want.err), longint'(error_now_o));
        check_field("done_res", longint'(want.done), longint'(done_res_o));
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (in_fire) send_gap = draw_gap(in_calm);
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (pending_ticks.size() > 0) begin
        next_tick = pending_ticks.pop_front();
        in_valid_i    <= 1'b1;
        op_i          <= next_tick.op;
        left_count_i  <= next_tick.lc;
        right_count_i <= next_tick.rc;
        sonar_valid_i <= next_tick.sv;
        sonar_mm_i    <= next_tick.mm;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_fire) hold_gap = draw_gap(out_calm);
    if (hold_gap > 0) begin
      out_stall_i <= 1'b1;
      hold_gap--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic put_tick(logic op, longint lc, longint rc, logic sv, longint mm);
    tick_t t;
    t.op = op;
    t.lc = lc;
    t.rc = rc;
    t.sv = sv;
    t.mm = mm;
    pending_ticks.push_back(t);
    queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_ticks.size() != 0 || in_valid_i || pending_powers.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_val(int p, int w, int hi);
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] junk;
    int                    r;
    mask = (1 << w) - 1;
    junk = $urandom() & ~mask;
    r    = rnd(0, 9);
    if (p == 0) return '0;
    if (p == 1) return '1;
    if (r == 0) return junk;
    if (r == 1) return junk | mask;
    return junk | (rnd(0, hi) & mask);
  endfunction

  task automatic configure(int p);
    write_reg(REG_TARGET,  pick_val(p, MM_W, 4095));
    write_reg(REG_TOL,     pick_val(p, MM_W, 30));
    write_reg(REG_DIST_KP, pick_val(p, GAIN_W, 200000));
    write_reg(REG_DIST_KI, pick_val(p, GAIN_W, 3000));
    write_reg(REG_TURN_KP, pick_val(p, GAIN_W, 100000));
    write_reg(REG_TURN_KI, pick_val(p, GAIN_W, 20000));
    write_reg(REG_SETTLE,  pick_val(p, TICK_W, 30));
    write_reg(REG_BAND,    pick_val(p, TICK_W, 300));
    write_reg(rnd(REG_COUNT, 2 ** CFG_IDX_W - 1), $urandom());
  endtask

  function automatic longint rand_count();
    case (rnd(0, 5))
      0: return CNT_MAX;
      1: return CNT_MIN;
      default: return longint'($signed(CNT_W'($urandom())));
    endcase
  endfunction

  task automatic add_approach_run();
    longint lc;
    longint rc;
    longint range_mm;
    int     n_search;
    int     n_appr;
    logic   sv;
    lc       = rnd(-50, 50);
    rc       = rnd(-50, 50);
    range_mm = clip(longint'(tgt_mm) + rnd(-600, 600), 0, MM_MAX);
    n_search = rnd(0, 6);
    n_appr   = rnd(4, 30) + ((settle_need > 40) ? 40 : int'(settle_need)) + 2;
    put_tick(OP_RESTART, rand_count(), rand_count(), rnd(0, 1), $urandom());
    for (int i = 0; i < n_search; i++) begin
      lc = clip(lc + rnd(0, 40), CNT_MIN, CNT_MAX);
      rc = clip(rc + rnd(0, 40), CNT_MIN, CNT_MAX);
      put_tick(OP_TICK, lc, rc, 1'b0, $urandom());
    end
    put_tick(OP_TICK, lc, rc, 1'b1, range_mm);
    for (int i = 0; i < n_appr; i++) begin
      lc       = clip(lc + rnd(0, 40), CNT_MIN, CNT_MAX);
      rc       = clip(rc + rnd(0, 40), CNT_MIN, CNT_MAX);
      range_mm = clip(range_mm + (longint'(tgt_mm) - range_mm) / rnd(2, 4) + rnd(-2, 2),
                      0, MM_MAX);
      sv       = (rnd(0, 9) != 0);
      put_tick(OP_TICK, lc, rc, sv, sv ? range_mm : longint'($urandom()));
    end
  endtask

  task automatic add_noise();
    int n;
    n = rnd(3, 12);
    for (int i = 0; i < n; i++)
      put_tick((rnd(0, 7) != 0) ? OP_TICK : OP_RESTART, rand_count(), rand_count(),
               rnd(0, 1), $urandom());
  endtask

  task automatic add_steer_saturation(bit up);
    put_tick(OP_RESTART, 0, 0, 1'b0, 0);
    for (int i = 0; i < 140; i++)
      put_tick(OP_TICK, up ? CNT_MAX : CNT_MIN, up ? CNT_MIN : CNT_MAX, 1'b0, $urandom());
    for (int i = 0; i < 4; i++)
      put_tick(OP_TICK, up ? CNT_MIN : CNT_MAX, up ? CNT_MAX : CNT_MIN, 1'b0, $urandom());
  endtask

  initial begin
    int base;
    reset_model();
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    put_tick(OP_RESTART, CNT_MAX, CNT_MIN, 1'b1, MM_MAX);
    put_tick(OP_TICK, CNT_MAX, CNT_MIN, 1'b0, 0);
    put_tick(OP_TICK, CNT_MIN, CNT_MAX, 1'b0, MM_MAX);
    put_tick(OP_TICK, 0, 0, 1'b0, 0);
    put_tick(OP_TICK, -1, 0, 1'b0, 0);
    put_tick(OP_TICK, 0, 0, 1'b1, MM_MAX);
    put_tick(OP_TICK, 0, 0, 1'b0, 0);
    put_tick(OP_TICK, 0, 0, 1'b1, MM_MAX);
    put_tick(OP_TICK, 0, 0, 1'b1, 0);
    put_tick(OP_TICK, 0, 0, 1'b1, 200);
    put_tick(OP_TICK, 0, 0, 1'b1, 250);
    put_tick(OP_TICK, 0, 0, 1'b0, 4000);
    put_tick(OP_TICK, 0, 0, 1'b1, 205);
    put_tick(OP_TICK, 0, 0, 1'b1, 210);
    put_tick(OP_RESTART, 0, 0, 1'b0, 0);
    drain();

    write_reg(REG_SETTLE, 1);
    put_tick(OP_RESTART, 0, 0, 1'b0, 0);
    put_tick(OP_TICK, 3, 1, 1'b1, 205);
    put_tick(OP_TICK, 5, 2, 1'b1, 205);
    put_tick(OP_TICK, 7, 3, 1'b1, 300);
    put_tick(OP_RESTART, 7, 3, 1'b1, 300);
    drain();

    write_reg(REG_SETTLE, 0);
    put_tick(OP_RESTART, 0, 0, 1'b0, 0);
    put_tick(OP_TICK, 1, 0, 1'b1, 900);
    put_tick(OP_TICK, 2, 0, 1'b1, 900);

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      configure(p);
      in_calm  = (rnd(0, 3) == 0);
      out_calm = (rnd(0, 3) == 0);
      base     = queued;
      if (p == 2) add_steer_saturation(1'b1);
      if (p == 3) add_steer_saturation(1'b0);
      while (queued - base < ITEMS_PER_PHASE) begin
        if (rnd(0, 9) < 7) add_approach_run();
        else add_noise();
      end
    end
    drain();

    if (bad_results == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/dttpi_pkg.sv
rtl/dttpi_power.sv
rtl/drive_to_target_pi.sv
test/tb_drive_to_target_pi.sv
